### rtl/mxq_pkg.sv
// mxq_pkg: shared types and constants for the min-extract queue.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package mxq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int COUNT_W         = 5;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_PUSH   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_PUSH,
        CELL_REMOVE
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_REMOVE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_mode                     mode;
        logic signed [FIELD_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [FIELD_W-1:0] front_value;
        logic signed [FIELD_W-1:0] min_value;
        logic [COUNT_W-1:0]        count;
        logic                      empty_res;
        logic                      dropped;
    } t_out_word;

endpackage

### rtl/mxq_cell.sv
// mxq_cell: one slot of the queue plus one stage of the running-minimum chain.
// Depends on mxq_pkg.
`timescale 1ns / 1ps

module mxq_cell #(
    parameter int INDEX       = 0,
    parameter int CAPACITY    = mxq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = mxq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mxq_pkg::t_cell_op             i_op,
    input  logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  logic [$clog2(CAPACITY)-1:0]   i_kill_idx,
    input  logic signed [VALUE_WIDTH-1:0] i_new_val,
    input  logic signed [VALUE_WIDTH-1:0] i_left_val,
    input  logic signed [VALUE_WIDTH-1:0] i_right_val,
    input  logic                          i_prev_any,
    input  logic signed [VALUE_WIDTH-1:0] i_prev_val,
    input  logic [$clog2(CAPACITY)-1:0]   i_prev_idx,
    output logic signed [VALUE_WIDTH-1:0] o_entry,
    output logic                          o_run_any,
    output logic signed [VALUE_WIDTH-1:0] o_run_val,
    output logic [$clog2(CAPACITY)-1:0]   o_run_idx
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    logic signed [VALUE_WIDTH-1:0] r_entry;
    logic signed [VALUE_WIDTH-1:0] n_entry;
    logic                          r_run_any;
    logic signed [VALUE_WIDTH-1:0] r_run_val;
    logic [IW-1:0]                 r_run_idx;
    logic                          occupied;
    logic                          take_own;

    assign occupied = CW'(INDEX) < i_count;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            mxq_pkg::CELL_APPEND: begin
                if (CW'(INDEX) == i_count) begin
                    n_entry = i_new_val;
                end
            end
            mxq_pkg::CELL_PUSH: begin
                n_entry = i_left_val;
            end
            mxq_pkg::CELL_REMOVE: begin
                if (IW'(INDEX) >= i_kill_idx) begin
                    n_entry = i_right_val;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // strict less-than keeps the earliest of tied minima
    assign take_own = occupied && (!i_prev_any || (r_entry < i_prev_val));

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (take_own) begin
            r_run_val <= r_entry;
            r_run_idx <= IW'(INDEX);
        end else begin
            r_run_val <= i_prev_val;
            r_run_idx <= i_prev_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_any <= 1'b0;
        end else begin
            r_run_any <= i_prev_any || occupied;
        end
    end

    assign o_entry   = r_entry;
    assign o_run_any = r_run_any;
    assign o_run_val = r_run_val;
    assign o_run_idx = r_run_idx;

endmodule

### rtl/mxq_ctrl.sv
// mxq_ctrl: operation sequencer, fill count and result register.
// Depends on mxq_pkg; drives the cell row built in the top level.
`timescale 1ns / 1ps

module mxq_ctrl #(
    parameter int CAPACITY    = mxq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = mxq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mxq_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mxq_pkg::t_out_word            o_out_word,
    output mxq_pkg::t_cell_op             o_cell_op,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic signed [VALUE_WIDTH-1:0] o_new_val,
    input  logic signed [VALUE_WIDTH-1:0] i_front_val,
    input  logic                          i_min_any,
    input  logic signed [VALUE_WIDTH-1:0] i_min_val
);

    localparam int CW = $clog2(CAPACITY+1);

    mxq_pkg::t_state    r_state;
    mxq_pkg::t_state    n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_scan_cnt;
    logic [CW-1:0]      n_scan_cnt;
    logic               r_drop;
    logic               n_drop;
    mxq_pkg::t_out_word r_out;
    mxq_pkg::t_out_word n_out;
    logic               in_acc;
    logic               full;
    logic               scan_done;
    logic signed [63:0] new_ext;
    logic [63:0]        front_ext;
    logic [63:0]        min_ext;
    logic [63:0]        count_ext;

    assign in_acc    = i_in_valid && (r_state == mxq_pkg::ST_IDLE);
    assign full      = r_count == CW'(CAPACITY);
    // the scan counter runs from 0 up to CAPACITY: cell 0 must first see the updated entry
    assign scan_done = r_scan_cnt == CW'(CAPACITY);

    assign new_ext   = 64'($signed(i_in_word.value));
    assign o_new_val = new_ext[VALUE_WIDTH-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mxq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.mode == mxq_pkg::MODE_REMOVE && r_count != '0) begin
                        n_state = mxq_pkg::ST_FIND;
                    end else begin
                        n_state = mxq_pkg::ST_SCAN;
                    end
                end
            end
            mxq_pkg::ST_FIND: begin
                if (scan_done) begin
                    n_state = mxq_pkg::ST_REMOVE;
                end
            end
            mxq_pkg::ST_REMOVE: begin
                n_state = mxq_pkg::ST_SCAN;
            end
            mxq_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = mxq_pkg::ST_RESULT;
                end
            end
            mxq_pkg::ST_RESULT: begin
                if (!i_out_stall) begin
                    n_state = mxq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mxq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_cell_op  = mxq_pkg::CELL_HOLD;
        n_count    = r_count;
        n_drop     = r_drop;
        n_scan_cnt = '0;
        case (r_state)
            mxq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_drop = 1'b0;
                    if (i_in_word.mode == mxq_pkg::MODE_APPEND ||
                        i_in_word.mode == mxq_pkg::MODE_PUSH) begin
                        if (full) begin
                            n_drop = 1'b1;
                        end else begin
                            o_cell_op = (i_in_word.mode == mxq_pkg::MODE_APPEND) ?
                                        mxq_pkg::CELL_APPEND : mxq_pkg::CELL_PUSH;
                            n_count   = r_count + CW'(1);
                        end
                    end
                end
            end
            mxq_pkg::ST_FIND, mxq_pkg::ST_SCAN: begin
                n_scan_cnt = scan_done ? '0 : r_scan_cnt + CW'(1);
            end
            mxq_pkg::ST_REMOVE: begin
                o_cell_op = mxq_pkg::CELL_REMOVE;
                n_count   = r_count - CW'(1);
            end
            default: begin
                o_cell_op = mxq_pkg::CELL_HOLD;
            end
        endcase
    end

    // result word; stored values are reported zero-extended from the low field bits
    assign front_ext = 64'($unsigned(i_front_val));
    assign min_ext   = 64'($unsigned(i_min_val));
    assign count_ext = 64'(r_count);

    always_comb begin
        n_out.front_value = (r_count != '0) ? front_ext[mxq_pkg::FIELD_W-1:0] : '0;
        n_out.min_value   = i_min_any ? min_ext[mxq_pkg::FIELD_W-1:0] : '0;
        n_out.count       = count_ext[mxq_pkg::COUNT_W-1:0];
        n_out.empty_res   = (r_count == '0);
        n_out.dropped     = r_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mxq_pkg::ST_IDLE;
            r_count    <= '0;
            r_scan_cnt <= '0;
            r_drop     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_scan_cnt <= n_scan_cnt;
            r_drop     <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mxq_pkg::ST_SCAN && scan_done) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != mxq_pkg::ST_IDLE);
    assign o_out_valid = (r_state == mxq_pkg::ST_RESULT);
    assign o_out_word  = r_out;
    assign o_count     = r_count;

endmodule

### rtl/min_extract_queue_unit.sv
// min_extract_queue_unit: top level, a row of CAPACITY queue cells plus sequencer.
// Depends on mxq_pkg, mxq_cell and mxq_ctrl.
//
//   channel  direction  handshake               word
//   in       input      i_in_valid/o_in_stall   i_in_word  (t_in_word)
//   out      output     o_out_valid/i_out_stall o_out_word (t_out_word)
//
// Append, push front and query walk the minimum chain once, in ST_SCAN, before the
// result is valid; remove on a non-empty queue walks it in ST_FIND to find the victim,
// applies the removal in ST_REMOVE and walks it again in ST_SCAN for the reported
// minimum. Each cell adds one registered compare stage to the chain.
// Reset is synchronous, active low, and leaves the queue empty.
// One word is in flight at a time; o_in_stall stays high until the result is taken.
`timescale 1ns / 1ps

module min_extract_queue_unit #(
    parameter int CAPACITY    = mxq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = mxq_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mxq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mxq_pkg::t_out_word o_out_word
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);

    mxq_pkg::t_cell_op             cell_op;
    logic [CW-1:0]                 count;
    logic signed [VALUE_WIDTH-1:0] new_val;
    logic signed [VALUE_WIDTH-1:0] entry   [CAPACITY];
    logic                          run_any [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] run_val [CAPACITY];
    logic [IW-1:0]                 run_idx [CAPACITY];

    mxq_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_cell_op   (cell_op),
        .o_count     (count),
        .o_new_val   (new_val),
        .i_front_val (entry[0]),
        .i_min_any   (run_any[CAPACITY-1]),
        .i_min_val   (run_val[CAPACITY-1])
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] left_val;
        logic signed [VALUE_WIDTH-1:0] right_val;
        logic                          prev_any;
        logic signed [VALUE_WIDTH-1:0] prev_val;
        logic [IW-1:0]                 prev_idx;

        if (g == 0) begin : g_head
            // push front feeds the new word in at the head
            assign left_val = new_val;
            assign prev_any = 1'b0;
            assign prev_val = '0;
            assign prev_idx = '0;
        end else begin : g_body
            assign left_val = entry[g-1];
            assign prev_any = run_any[g-1];
            assign prev_val = run_val[g-1];
            assign prev_idx = run_idx[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_val = entry[g];
        end else begin : g_mid
            assign right_val = entry[g+1];
        end

        mxq_cell #(
            .INDEX       (g),
            .CAPACITY    (CAPACITY),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_op        (cell_op),
            .i_count     (count),
            .i_kill_idx  (run_idx[CAPACITY-1]),
            .i_new_val   (new_val),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .i_prev_any  (prev_any),
            .i_prev_val  (prev_val),
            .i_prev_idx  (prev_idx),
            .o_entry     (entry[g]),
            .o_run_any   (run_any[g]),
            .o_run_val   (run_val[g]),
            .o_run_idx   (run_idx[g])
        );
    end

endmodule

### dv/min_extract_queue_unit_tb.sv
// min_extract_queue_unit_tb: self-checking bench for the min-extract queue.
// Drives operation words, predicts each status word and compares field by field.
// Depends on mxq_pkg and min_extract_queue_unit.
`timescale 1ns / 1ps

module min_extract_queue_unit_tb;

    localparam int DEPTH         = mxq_pkg::CAPACITY_DEF;
    localparam int VW            = mxq_pkg::FIELD_W;
    localparam int CNT_W         = mxq_pkg::COUNT_W;
    localparam int N_RANDOM      = 1625;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 12;
    localparam int QUIET_LIMIT   = 5000;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        mxq_pkg::t_in_word word;
        bit                wait_drained;
    } t_pending_op;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    logic               out_stall = 1'b0;
    mxq_pkg::t_in_word  in_word   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    mxq_pkg::t_out_word o_out_word;

    t_pending_op        pending_ops[$];
    mxq_pkg::t_out_word expected_status[$];
    logic signed [VW-1:0] model_store[DEPTH];
    int            model_fill     = 0;
    int            n_sent         = 0;
    int            n_checked      = 0;
    int            n_errors       = 0;
    int            n_refused      = 0;
    int            n_empty_remove = 0;
    int            total_ops      = 0;
    int            quiet_cycles   = 0;
    int            hold_left      = 0;
    bit            hold_done      = 1'b0;

    min_extract_queue_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    // first-occurring minimum, scanning from the front
    function automatic int min_slot();
        int best;
        best = 0;
        for (int i = 1; i < model_fill; i++)
            if (model_store[i] < model_store[best])
                best = i;
        return best;
    endfunction

    function automatic mxq_pkg::t_out_word predict_queue_op(mxq_pkg::t_in_word w);
        mxq_pkg::t_out_word r;
        int                 victim;
        r = '0;
        case (w.mode)
            mxq_pkg::MODE_APPEND, mxq_pkg::MODE_PUSH: begin
                if (model_fill >= DEPTH) begin
                    r.dropped = 1'b1;
                    n_refused++;
                end else if (w.mode == mxq_pkg::MODE_APPEND) begin
                    model_store[model_fill] = w.value;
                    model_fill++;
                end else begin
                    for (int i = model_fill; i > 0; i--)
                        model_store[i] = model_store[i - 1];
                    model_store[0] = w.value;
                    model_fill++;
                end
            end
            mxq_pkg::MODE_REMOVE: begin
                if (model_fill == 0) begin
                    n_empty_remove++;
                end else begin
                    victim = min_slot();
                    for (int i = victim; i + 1 < model_fill; i++)
                        model_store[i] = model_store[i + 1];
                    model_fill--;
                end
            end
            default: ;
        endcase
        r.count     = CNT_W'(model_fill);
        r.empty_res = (model_fill == 0);
        if (model_fill != 0) begin
            r.front_value = model_store[0];
            r.min_value   = model_store[min_slot()];
        end
        return r;
    endfunction

    task automatic add_op(mxq_pkg::t_mode m, logic signed [VW-1:0] v,
                          bit wait_drained = 1'b0);
        t_pending_op p;
        p.word.mode    = m;
        p.word.value   = v;
        p.wait_drained = wait_drained;
        pending_ops.push_back(p);
    endtask

    // extremes, a narrow band for ties, and the full range
    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3, 4: return VW'(int'($urandom_range(0, 8)) - 4);
            default: return VW'($urandom);
        endcase
    endfunction

    // driver: prediction is taken at the edge where the word is accepted
    always @(posedge i_clk) begin
        t_pending_op nxt;
        bit          offer;
        int          idle;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_status.push_back(predict_queue_op(in_word));
                n_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                idle  = (n_sent >= 900 && n_sent < 1150) ? 0 : IDLE_PCT;
                offer = pending_ops.size() != 0 && $urandom_range(0, 99) >= idle;
                if (offer && pending_ops[0].wait_drained && expected_status.size() != 0)
                    offer = 1'b0;
                if (offer) begin
                    nxt = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    in_word  <= nxt.word;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        mxq_pkg::t_out_word want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              n_checked));
                end else begin
                    want = expected_status.pop_front();
                    if (o_out_word.front_value !== want.front_value)
                        report_mismatch($sformatf("result %0d front_value got %0d want %0d",
                            n_checked, o_out_word.front_value, want.front_value));
                    if (o_out_word.min_value !== want.min_value)
                        report_mismatch($sformatf("result %0d min_value got %0d want %0d",
                            n_checked, o_out_word.min_value, want.min_value));
                    if (o_out_word.count !== want.count)
                        report_mismatch($sformatf("result %0d count got %0d want %0d",
                            n_checked, o_out_word.count, want.count));
                    if (o_out_word.empty_res !== want.empty_res)
                        report_mismatch($sformatf("result %0d empty_res got %b want %b",
                            n_checked, o_out_word.empty_res, want.empty_res));
                    if (o_out_word.dropped !== want.dropped)
                        report_mismatch($sformatf("result %0d dropped got %b want %b",
                            n_checked, o_out_word.dropped, want.dropped));
                end
                n_checked++;
            end
            // one long hold-off so the input side backs up
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (n_checked == HOLD_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (n_checked >= 880 && n_checked < 1150) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("** min_extract_queue_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int bias;
        // directed: empty-queue cases, extremes, front minimum, ties, full queue
        add_op(mxq_pkg::MODE_REMOVE, 16'sh1234);
        add_op(mxq_pkg::MODE_QUERY, 16'shffff);
        add_op(mxq_pkg::MODE_APPEND, 16'sh7fff);
        add_op(mxq_pkg::MODE_PUSH, 16'sh8000);
        add_op(mxq_pkg::MODE_APPEND, 16'sh0000);
        add_op(mxq_pkg::MODE_QUERY, 16'sh5a5a);
        add_op(mxq_pkg::MODE_REMOVE, 16'sh0000);
        add_op(mxq_pkg::MODE_PUSH, -16'sd1);
        add_op(mxq_pkg::MODE_APPEND, -16'sd1);
        add_op(mxq_pkg::MODE_REMOVE, 16'sh7fff);
        for (int i = 0; i < 13; i++)
            add_op(mxq_pkg::MODE_APPEND, pick_value());
        add_op(mxq_pkg::MODE_APPEND, 16'sh8000);
        add_op(mxq_pkg::MODE_PUSH, 16'sh8000);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0)
                bias = $urandom_range(0, 3);
            case (bias)
                0:       add_op(($urandom_range(0, 99) < 75)
                                ? mxq_pkg::t_mode'($urandom_range(0, 1))
                                : mxq_pkg::t_mode'($urandom_range(2, 3)), pick_value(),
                                n == 600 || n == 1200);
                1:       add_op(($urandom_range(0, 99) < 70) ? mxq_pkg::MODE_REMOVE
                                : mxq_pkg::t_mode'($urandom_range(0, 3)), pick_value(),
                                n == 600 || n == 1200);
                default: add_op(mxq_pkg::t_mode'($urandom_range(0, 3)), pick_value(),
                                n == 600 || n == 1200);
            endcase
        end
        total_ops = pending_ops.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < total_ops || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d operations and %0d status words, with %0d inserts refused",
                 n_sent, n_checked, n_refused);
        $display("on a full queue and %0d removals on an empty one.", n_empty_remove);
        if (n_errors == 0)
            $display("** min_extract_queue_unit: PASSED **");
        else
            $display("** min_extract_queue_unit: FAILED **");
        $finish;
    end

endmodule
